// ----- hdl/ahfe_pkg.sv -----
package ahfe_pkg;

   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] LF_RESET       = 8'h0A;
   localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;  // '0'
   localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;  // 'A' - 10
   localparam logic [3:0] HEX_MAX_DIGIT  = 4'd9;

   // one frame byte as the back end needs it
   typedef struct packed {
      logic [7:0] data;
      logic       colon;   // first byte of frame: ':' goes ahead
      logic       fin;     // closes the frame: LRC, CR, LF follow
      logic [7:0] lrc;     // valid when fin
   } cmd_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] wide;
      wide = {4'b0000, nibble};
      if (nibble <= HEX_MAX_DIGIT) begin
         return HEX_DIGIT_BASE + wide;
      end
      return HEX_ALPHA_BASE + wide;
   endfunction

endpackage

// ----- hdl/ahfe_front.sv -----
module ahfe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_frame_byte,
   input  logic               req_last_byte,
   output logic               push,
   output ahfe_pkg::cmd_type  push_cmd,
   input  logic               queue_full
);

   typedef enum logic [1:0] {
      POS_ADDRESS  = 2'd0,
      POS_FUNCTION = 2'd1,
      POS_DATA     = 2'd2
   } pos_type;

   pos_type    pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] sum_next;
   logic       is_addr;
   logic       accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_addr   = (pos_ff == POS_ADDRESS);
   assign sum_next  = sum_ff + req_frame_byte;

   always_comb begin
      push_cmd.data  = req_frame_byte;
      push_cmd.colon = is_addr;
      push_cmd.fin   = !is_addr && req_last_byte;
      push_cmd.lrc   = 8'h00 - sum_next;
   end

   assign push = accept;

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (accept) begin
         sum_in = sum_next;
         case (pos_ff)
            POS_ADDRESS: pos_in = POS_FUNCTION;
            default: begin
               // last flag on the address byte is ignored above
               if (req_last_byte) begin
                  pos_in = POS_ADDRESS;
                  sum_in = 8'h00;
               end else begin
                  pos_in = POS_DATA;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_ADDRESS;
         sum_ff <= 8'h00;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

`ifndef SYNTH
   a_addr_then_func: assert property (@(posedge clock) disable iff (reset)
      (accept && is_addr) |=> (pos_ff == POS_FUNCTION))
      else $error("address byte not followed by function position");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (accept && push_cmd.fin) |=> (sum_ff == 8'h00 && pos_ff == POS_ADDRESS))
      else $error("frame end did not clear sum and position");

   a_lrc_checks: assert property (@(posedge clock) disable iff (reset)
      push |-> ((push_cmd.lrc + sum_next) == 8'h00))
      else $error("lrc is not the complement of the sum");
`endif

endmodule

// ----- hdl/ahfe_queue.sv -----
module ahfe_queue #(
   parameter int DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ahfe_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output ahfe_pkg::cmd_type  head,
   output logic               head_valid
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ahfe_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/ahfe_back.sv -----
module ahfe_back (
   input  logic               clock,
   input  logic               reset,
   input  ahfe_pkg::cmd_type  head,
   input  logic               head_valid,
   output logic               pop,
   input  logic [7:0]         line_feed_char,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_tx_char,
   output logic               rsp_run_last,
   output logic               rsp_frame_done
);

   typedef enum logic [2:0] {
      STEP_COLON  = 3'd0,
      STEP_HI     = 3'd1,
      STEP_LO     = 3'd2,
      STEP_LRC_HI = 3'd3,
      STEP_LRC_LO = 3'd4,
      STEP_CR     = 3'd5,
      STEP_LF     = 3'd6
   } step_type;

   step_type   step_ff, step_in, cur_step;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic       run_last_ff, run_last_in;
   logic       done_ff, done_in;
   logic       load;
   logic       last_step;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);

   // no colon on bytes after the address: start straight at the high nibble
   assign cur_step = (step_ff == STEP_COLON && !head.colon) ? STEP_HI : step_ff;
   assign last_step = (cur_step == STEP_LO && !head.fin) || (cur_step == STEP_LF);

   always_comb begin
      case (cur_step)
         STEP_COLON:  char_in = ahfe_pkg::CHAR_COLON;
         STEP_HI:     char_in = ahfe_pkg::hex_char(head.data[7:4]);
         STEP_LO:     char_in = ahfe_pkg::hex_char(head.data[3:0]);
         STEP_LRC_HI: char_in = ahfe_pkg::hex_char(head.lrc[7:4]);
         STEP_LRC_LO: char_in = ahfe_pkg::hex_char(head.lrc[3:0]);
         STEP_CR:     char_in = ahfe_pkg::CHAR_CR;
         STEP_LF:     char_in = line_feed_char;
         default:     char_in = ahfe_pkg::CHAR_CR;
      endcase
   end

   always_comb begin
      case (cur_step)
         STEP_COLON:  step_in = STEP_HI;
         STEP_HI:     step_in = STEP_LO;
         STEP_LO:     step_in = head.fin ? STEP_LRC_HI : STEP_COLON;
         STEP_LRC_HI: step_in = STEP_LRC_LO;
         STEP_LRC_LO: step_in = STEP_CR;
         STEP_CR:     step_in = STEP_LF;
         default:     step_in = STEP_COLON;
      endcase
      if (!load) begin
         step_in = step_ff;
      end
   end

   assign run_last_in  = last_step;
   assign done_in      = (cur_step == STEP_LF);
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign pop          = load && last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_COLON;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff     <= char_in;
         run_last_ff <= run_last_in;
         done_ff     <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_char    = char_ff;
   assign rsp_run_last   = run_last_ff;
   assign rsp_frame_done = done_ff;

`ifndef SYNTH
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> run_last_ff)
      else $error("frame end word not marked last");

   a_step_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> (step_ff == STEP_COLON))
      else $error("sequencer did not rewind after a byte");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!load && rsp_valid_ff) |=> $stable(step_ff))
      else $error("sequencer moved without loading a word");
`endif

endmodule

// ----- hdl/ascii_hex_frame_encoder_lrc.sv -----
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_stall      req_frame_byte, req_last_byte
// rsp       out        rsp_valid / rsp_stall      rsp_tx_char, rsp_run_last, rsp_frame_done
// csr       in         APB, pready tied high      line_feed_char at byte address 0
//
// One character leaves per cycle while rsp_stall is low; a byte takes 2, 3 (address)
// or 6 (closing byte) characters of the output sequencer, which sets the sustained rate.
// The front end accepts a byte per cycle until the QUEUE_DEPTH-entry queue is full.
// First character of a byte reaches rsp through the queue and then the output register.
// Reset is synchronous: frame position and sum cleared, line feed back to 0x0A.
// rsp_stall holds the output register and, once the queue fills, req_stall rises.
module ascii_hex_frame_encoder_lrc #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_char,
   output logic        rsp_run_last,
   output logic        rsp_frame_done,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [2:0] ADDR_LINE_FEED = 3'd0;

   ahfe_pkg::cmd_type push_cmd, head;
   logic              push, queue_full, pop, head_valid;
   logic [7:0]        lf_ff;
   logic              csr_write;
   logic              sel_lf;

   assign csr_pready = 1'b1;
   assign sel_lf     = (csr_paddr == ADDR_LINE_FEED);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = sel_lf ? {24'h000000, lf_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         lf_ff <= ahfe_pkg::LF_RESET;
      end else if (csr_write && sel_lf) begin
         lf_ff <= csr_pwdata[7:0];
      end
   end

   ahfe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_byte (req_frame_byte),
      .req_last_byte  (req_last_byte),
      .push           (push),
      .push_cmd       (push_cmd),
      .queue_full     (queue_full)
   );

   ahfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   ahfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop),
      .line_feed_char (lf_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_char    (rsp_tx_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule
